// ===== hdl/color_key_blend_pixel_core_macros.svh =====
// Assertion macros for the color key blend pixel core.
`ifndef COLOR_KEY_BLEND_PIXEL_CORE_MACROS_SVH
`define COLOR_KEY_BLEND_PIXEL_CORE_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define CKB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("color key blend check failed");
// Check a property on every clock edge, reset included.
`define CKB_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("color key blend check failed");
`else
`define CKB_ASSERT(lbl, prop)
`define CKB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/ckb_pkg.sv =====
// Package of the color key blend pixel core: word types and register codes.
package ckb_pkg;

	// Input word: sprite pixel and the background pixel under it
	typedef struct packed {
		logic [23:0] sprite_pixel;
		logic [23:0] back_pixel;
	} px_word_t;

	// Result word
	typedef struct packed {
		logic [23:0] out_pixel;
		logic        keyed;
	} res_word_t;

	// Register indexes
	localparam logic [2:0] CFG_KEY_COLOR     = 3'd0;
	localparam logic [2:0] CFG_KEY_TOLERANCE = 3'd1;
	localparam logic [2:0] CFG_GAIN_Q8       = 3'd2;
	localparam logic [2:0] CFG_OPACITY       = 3'd3;
	localparam logic [2:0] CFG_EFFECT_MODE   = 3'd4;

	// Effect modes
	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_INVERT = 2'd1;
	localparam logic [1:0] MODE_GREY   = 2'd2;

	// Gain values that leave the channels unchanged
	localparam logic [11:0] GAIN_OFF  = 12'd0;
	localparam logic [11:0] GAIN_UNIT = 12'd256;

	// Opacity is a percent
	localparam logic [6:0] OPACITY_FULL = 7'd100;

	// Grey weights in Q0.8
	localparam logic [15:0] GREY_W0 = 16'd77;
	localparam logic [15:0] GREY_W1 = 16'd150;
	localparam logic [15:0] GREY_W2 = 16'd29;

	// Divide by 100 for sums up to 25500: (x * RECIP_100) >> RECIP_SHIFT
	localparam logic [15:0] RECIP_100   = 16'd41944;
	localparam int          RECIP_SHIFT = 22;

endpackage

// ===== hdl/color_key_blend_pixel_core.sv =====
// Color key blend pixel core: five-stage compositing pipeline, one pixel per clock unless stalled.
//
// Input channel px / px_valid / px_stall carries a sprite pixel and the
// background pixel under it; result channel res / res_valid / res_stall
// carries the composited pixel and the keyed flag. A word moves at a rising
// edge with valid high and stall low. Registers are written through
// cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is high outside
// reset and writes are meant to happen while the pipeline is empty.
// An accepted input word passes through the stages below to the result word;
// throughput is one pixel per clock while the result side does not stall. The
// stages are: key compare and gain multiply, gain saturate and grey weighting,
// opacity blend products, multiply by the reciprocal of 100, result register.
// A result-side stall with a word in the result register freezes the whole
// pipeline at once and raises px_stall in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline, holds px_stall high and cfg_ready low, and
// loads key 0, tolerance 0, gain 1.0, opacity 100 and no effect.
`include "color_key_blend_pixel_core_macros.svh"

module color_key_blend_pixel_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 px_valid,
	output logic                 px_stall,
	input  ckb_pkg::px_word_t    px,
	output logic                 res_valid,
	input  logic                 res_stall,
	output ckb_pkg::res_word_t   res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [23:0]          cfg_data
);

	// Configuration registers
	logic [23:0] key_q;
	logic [8:0]  tol_q;
	logic [11:0] gain_q;
	logic [6:0]  opac_q;
	logic [1:0]  mode_q;

	// Pipeline
	logic                   adv;
	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic                   byp_s1, byp_s2, byp_s3, byp_s4;
	logic                   keyed_s1, keyed_s2, keyed_s3, keyed_s4;
	logic [23:0]            alt_s1, alt_s2, alt_s3, alt_s4;
	logic [23:0]            back_s1, back_s2;
	logic [2:0][7:0]        raw_s1;
	logic [2:0][19:0]       gprod_s1;
	logic [2:0][7:0]        chan_s2;
	logic [2:0][14:0]       sum_s3;
	logic [2:0][30:0]       prod_s4;
	ckb_pkg::res_word_t     res_q;
	logic                   res_valid_q;

	// Combinational
	logic [2:0]             chan_match;
	logic                   match;
	logic [2:0][7:0]        gained;
	logic [2:0][7:0]        shaded;
	logic [15:0]            grey_sum;
	logic [6:0]             opac_inv;
	logic [23:0]            quot;

	assign cfg_ready = arst_n;
	assign adv       = !(res_valid_q && res_stall);
	assign px_stall  = !adv || !arst_n;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Write configuration registers; clamp opacity to 100
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= 24'd0;
			tol_q  <= 9'd0;
			gain_q <= ckb_pkg::GAIN_UNIT;
			opac_q <= ckb_pkg::OPACITY_FULL;
			mode_q <= ckb_pkg::MODE_NONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				ckb_pkg::CFG_KEY_COLOR:     key_q  <= cfg_data;
				ckb_pkg::CFG_KEY_TOLERANCE: tol_q  <= cfg_data[8:0];
				ckb_pkg::CFG_GAIN_Q8:       gain_q <= cfg_data[11:0];
				ckb_pkg::CFG_OPACITY: begin
					opac_q <= (cfg_data[6:0] > ckb_pkg::OPACITY_FULL) ?
						ckb_pkg::OPACITY_FULL : cfg_data[6:0];
				end
				ckb_pkg::CFG_EFFECT_MODE:   mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Compare each channel with the key; a negative tolerance never matches
	always_comb begin
		logic [7:0] s, k, d;
		for (int i = 0; i < 3; i++) begin
			s = px.sprite_pixel[8*i +: 8];
			k = key_q[8*i +: 8];
			d = (s >= k) ? (s - k) : (k - s);
			chan_match[i] = ($signed({1'b0, d}) <= $signed(tol_q));
		end
		match = &chan_match;
	end

	// Stage 1: key decision, invert word, gain products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= px_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keyed_s1 <= match;
			byp_s1   <= match || (mode_q == ckb_pkg::MODE_INVERT);
			alt_s1   <= match ? px.back_pixel : ~px.sprite_pixel;
			back_s1  <= px.back_pixel;
			for (int i = 0; i < 3; i++) begin
				raw_s1[i]   <= px.sprite_pixel[8*i +: 8];
				gprod_s1[i] <= {12'd0, px.sprite_pixel[8*i +: 8]} * {8'd0, gain_q};
			end
		end
	end

	// Saturate the gained channels and apply grey weighting
	always_comb begin
		logic [11:0] v;
		for (int i = 0; i < 3; i++) begin
			v = gprod_s1[i][19:8];
			if (gain_q == ckb_pkg::GAIN_OFF || gain_q == ckb_pkg::GAIN_UNIT) begin
				gained[i] = raw_s1[i];
			end else if (v > 12'd255) begin
				gained[i] = 8'hFF;
			end else begin
				gained[i] = v[7:0];
			end
		end
		grey_sum = {8'd0, gained[0]} * ckb_pkg::GREY_W0
			+ {8'd0, gained[1]} * ckb_pkg::GREY_W1
			+ {8'd0, gained[2]} * ckb_pkg::GREY_W2;
		for (int i = 0; i < 3; i++) begin
			shaded[i] = (mode_q == ckb_pkg::MODE_GREY) ? grey_sum[15:8] : gained[i];
		end
	end

	// Stage 2: shaded sprite channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keyed_s2 <= keyed_s1;
			byp_s2   <= byp_s1;
			alt_s2   <= alt_s1;
			back_s2  <= back_s1;
			chan_s2  <= shaded;
		end
	end

	assign opac_inv = ckb_pkg::OPACITY_FULL - opac_q;

	// Stage 3: weighted sum of sprite and background per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keyed_s3 <= keyed_s2;
			byp_s3   <= byp_s2;
			alt_s3   <= alt_s2;
			for (int i = 0; i < 3; i++) begin
				sum_s3[i] <= {7'd0, chan_s2[i]} * {8'd0, opac_q}
					+ {7'd0, back_s2[8*i +: 8]} * {8'd0, opac_inv};
			end
		end
	end

	// Stage 4: multiply by the reciprocal of 100
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keyed_s4 <= keyed_s3;
			byp_s4   <= byp_s3;
			alt_s4   <= alt_s3;
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= {16'd0, sum_s3[i]} * {15'd0, ckb_pkg::RECIP_100};
			end
		end
	end

	// Take the quotient bits of each channel
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quot[8*i +: 8] = prod_s4[i][ckb_pkg::RECIP_SHIFT +: 8];
		end
	end

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.out_pixel <= byp_s4 ? alt_s4 : quot;
			res_q.keyed     <= keyed_s4;
		end
	end

	// The input side stalls only behind a full, stalled result register
	`CKB_ASSERT(a_stall_source, px_stall |-> (res_valid_q && res_stall))
	// The blend quotient always fits in one channel
	`CKB_ASSERT(a_quot_fits, (valid_s4 && !byp_s4) |-> (prod_s4[0][30] == 1'b0
		&& prod_s4[1][30] == 1'b0 && prod_s4[2][30] == 1'b0))
	// Stored opacity never exceeds full
	`CKB_ASSERT(a_opac_range, opac_q <= ckb_pkg::OPACITY_FULL)
	// A keyed word always bypasses the blend path
	`CKB_ASSERT(a_keyed_bypass, (valid_s4 && keyed_s4) |-> byp_s4)

endmodule

// ===== test/tb.sv =====
// Testbench of the color key blend pixel core: directed and random pixel words against a predictor.
module tb;

	localparam int          LATENCY      = 5;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          PHASES       = 4;
	localparam int          SETS_PER_PH  = 4;
	localparam int          PIXELS_PER   = 95;
	localparam logic [1:0]  MODE_SPARE   = 2'd3;
	localparam logic [23:0] WHITE        = 24'hFFFFFF;
	localparam logic [8:0]  TOL_OFF      = 9'h1FF;
	localparam logic [8:0]  TOL_MOST_NEG = 9'h100;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 px_valid = 1'b0;
	logic                 px_stall;
	ckb_pkg::px_word_t    px = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	ckb_pkg::res_word_t   res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [2:0]           cfg_index = '0;
	logic [23:0]          cfg_data = '0;

	// Register copies, reset values of the block
	logic [23:0]       key_color_r = '0;
	logic signed [8:0] key_tol_r = '0;
	logic [11:0]       gain_r = ckb_pkg::GAIN_UNIT;
	logic [6:0]        opacity_r = ckb_pkg::OPACITY_FULL;
	logic [1:0]        mode_r = ckb_pkg::MODE_NONE;

	ckb_pkg::px_word_t  pending_px[$];
	ckb_pkg::res_word_t expected_px[$];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        errors = 0;
	int        cycles = 0;

	color_key_blend_pixel_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.px_valid(px_valid),
		.px_stall(px_stall),
		.px(px),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Composite one pixel word with the current register copies
	function automatic ckb_pkg::res_word_t composite(ckb_pkg::px_word_t w);
		ckb_pkg::res_word_t r;
		logic [7:0] s [3];
		logic [7:0] b [3];
		int ch [3];
		int d;
		int grey;
		int v;
		bit hit;
		r = '0;
		hit = 1'b1;
		for (int k = 0; k < 3; k++) begin
			s[k] = w.sprite_pixel[8*k +: 8];
			b[k] = w.back_pixel[8*k +: 8];
			d = int'(s[k]) - int'(key_color_r[8*k +: 8]);
			if (d < 0)
				d = -d;
			if (d > int'(key_tol_r))
				hit = 1'b0;
		end
		if (hit) begin
			r.out_pixel = w.back_pixel;
			r.keyed = 1'b1;
			return r;
		end
		if (mode_r == ckb_pkg::MODE_INVERT) begin
			r.out_pixel = WHITE - w.sprite_pixel;
			return r;
		end
		// Gain, saturating only when it brightens
		for (int k = 0; k < 3; k++) begin
			if (gain_r == ckb_pkg::GAIN_OFF || gain_r == ckb_pkg::GAIN_UNIT) begin
				ch[k] = int'(s[k]);
			end else begin
				ch[k] = (int'(s[k]) * int'(gain_r)) >> 8;
				if (gain_r > ckb_pkg::GAIN_UNIT && ch[k] > 255)
					ch[k] = 255;
			end
		end
		if (mode_r == ckb_pkg::MODE_GREY) begin
			grey = (int'(ckb_pkg::GREY_W0) * ch[0] + int'(ckb_pkg::GREY_W1) * ch[1] +
				int'(ckb_pkg::GREY_W2) * ch[2]) >> 8;
			for (int k = 0; k < 3; k++)
				ch[k] = grey;
		end
		// Blend against the background, round down
		for (int k = 0; k < 3; k++) begin
			v = (ch[k] * int'(opacity_r) + int'(b[k]) *
				(int'(ckb_pkg::OPACITY_FULL) - int'(opacity_r))) /
				int'(ckb_pkg::OPACITY_FULL);
			r.out_pixel[8*k +: 8] = v[7:0];
		end
		return r;
	endfunction

	// Count a mismatch and log it
	task automatic report(input string msg);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	// Write one register and mirror it in the local copy
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			ckb_pkg::CFG_KEY_COLOR:     key_color_r = data;
			ckb_pkg::CFG_KEY_TOLERANCE: key_tol_r = data[8:0];
			ckb_pkg::CFG_GAIN_Q8:       gain_r = data[11:0];
			ckb_pkg::CFG_OPACITY: begin
				opacity_r = (data[6:0] > ckb_pkg::OPACITY_FULL) ?
					ckb_pkg::OPACITY_FULL : data[6:0];
			end
			ckb_pkg::CFG_EFFECT_MODE:   mode_r = data[1:0];
			default: ;
		endcase
	endtask

	// Write all five registers; junk fills the unused upper data bits
	task automatic set_regs(input logic [23:0] key, input logic [8:0] tol,
		input logic [11:0] gain, input logic [6:0] op, input logic [1:0] mode,
		input bit junk);
		logic [23:0] fill;
		fill = junk ? 24'($urandom) : '0;
		write_reg(ckb_pkg::CFG_KEY_COLOR, key);
		write_reg(ckb_pkg::CFG_KEY_TOLERANCE, {fill[23:9], tol});
		write_reg(ckb_pkg::CFG_GAIN_Q8, {fill[23:12], gain});
		write_reg(ckb_pkg::CFG_OPACITY, {fill[23:7], op});
		write_reg(ckb_pkg::CFG_EFFECT_MODE, {fill[23:2], mode});
	endtask

	task automatic queue_px(input logic [23:0] sp, input logic [23:0] bk);
		ckb_pkg::px_word_t w;
		w.sprite_pixel = sp;
		w.back_pixel = bk;
		pending_px.push_back(w);
	endtask

	// Wait until every word is through, then let the pipeline settle
	task automatic drain();
		do @(negedge clk);
		while (pending_px.size() != 0 || px_valid || expected_px.size() != 0);
		repeat (2 * LATENCY) @(negedge clk);
	endtask

	// Sprite pixel close to the key so that matches and near misses both occur
	function automatic logic [23:0] near_key_pixel();
		logic [23:0] p;
		int tol;
		int span;
		int v;
		tol = int'(key_tol_r);
		span = (tol < 0) ? 3 : ((tol > 60) ? 60 : tol + 1);
		for (int k = 0; k < 3; k++) begin
			v = int'(key_color_r[8*k +: 8]) + int'($urandom_range(0, 2 * span)) - span;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			p[8*k +: 8] = v[7:0];
		end
		return p;
	endfunction

	// Pick a register setting, extremes weighted in
	task automatic random_regs();
		logic [8:0]  tol;
		logic [11:0] gain;
		logic [6:0]  op;
		case ($urandom_range(0, 5))
			0: tol = TOL_OFF;
			1: tol = TOL_MOST_NEG;
			2: tol = 9'd0;
			3: tol = 9'd255;
			4: tol = 9'($urandom_range(0, 40));
			default: tol = 9'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: gain = ckb_pkg::GAIN_OFF;
			1: gain = ckb_pkg::GAIN_UNIT;
			2: gain = 12'hFFF;
			3: gain = 12'($urandom_range(1, 255));
			4: gain = 12'($urandom_range(257, 4095));
			default: gain = 12'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: op = 7'd0;
			1: op = ckb_pkg::OPACITY_FULL;
			default: op = 7'($urandom);
		endcase
		set_regs(24'($urandom), tol, gain, op, 2'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Drive input words: hold while stalled, otherwise advance or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (px_valid && !px_stall)
				expected_px.push_back(composite(px));
			if (!px_valid || !px_stall) begin
				if (pending_px.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					px <= pending_px.pop_front();
					px_valid <= 1'b1;
				end else begin
					px_valid <= 1'b0;
				end
			end
		end
	end

	// Check result words against the oldest expectation, stall at random
	always @(posedge clk) begin
		ckb_pkg::res_word_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_px.size() == 0) begin
					report($sformatf("result word %h/%0d with nothing expected",
						res.out_pixel, res.keyed));
				end else begin
					want = expected_px.pop_front();
					if (res.out_pixel !== want.out_pixel)
						report($sformatf("out_pixel %h, expected %h",
							res.out_pixel, want.out_pixel));
					if (res.keyed !== want.keyed)
						report($sformatf("keyed %b, expected %b", res.keyed, want.keyed));
				end
			end
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [23:0] sp;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: key black, exact match only
		@(negedge clk);
		queue_px(24'h000000, 24'hFFFFFF);
		queue_px(24'h000001, 24'h123456);
		queue_px(24'hFFFFFF, 24'h000000);
		queue_px(24'h800000, 24'hFFFFFF);
		drain();

		// Keying disabled, invert
		set_regs(24'h80FF00, TOL_OFF, ckb_pkg::GAIN_UNIT, ckb_pkg::OPACITY_FULL,
			ckb_pkg::MODE_INVERT, 1'b0);
		@(negedge clk);
		queue_px(24'h80FF00, 24'h000000);
		queue_px(24'h000000, 24'hFFFFFF);
		queue_px(24'hFFFFFF, 24'h000000);
		drain();

		// Widest tolerance: the key wins over invert
		set_regs(24'h5A5A5A, 9'd255, 12'hFFF, 7'd0, ckb_pkg::MODE_INVERT, 1'b0);
		@(negedge clk);
		queue_px(24'h000000, 24'h13579B);
		queue_px(24'hFFFFFF, 24'h2468AC);
		drain();

		// Tolerance edge, grey, maximum gain, half opacity
		set_regs(24'h10F0FE, 9'd3, 12'hFFF, 7'd50, ckb_pkg::MODE_GREY, 1'b0);
		@(negedge clk);
		queue_px(24'h13EDFB, 24'hAAAAAA);
		queue_px(24'h14F0FE, 24'h555555);
		queue_px(24'h10F4FE, 24'hC0FFEE);
		queue_px(24'h0DF0FF, 24'h0F0F0F);
		queue_px(24'hFFFFFF, 24'h000000);
		queue_px(24'h010203, 24'hFFFFFF);
		drain();

		// Most negative tolerance, zero gain, opacity overrange, spare mode
		set_regs(24'h000000, TOL_MOST_NEG, ckb_pkg::GAIN_OFF, 7'd127, MODE_SPARE, 1'b1);
		@(negedge clk);
		queue_px(24'h000000, 24'hFFFFFF);
		queue_px(24'hABCDEF, 24'h000000);
		drain();

		// Dimming gain, partial opacity
		set_regs(24'hFFFFFF, 9'd0, 12'd128, 7'd73, ckb_pkg::MODE_NONE, 1'b0);
		@(negedge clk);
		queue_px(24'hFFFFFF, 24'h000000);
		queue_px(24'hFFFFFE, 24'h000000);
		queue_px(24'h808080, 24'hFFFFFF);
		drain();

		// Gain just above one, opacity just over the top
		set_regs(24'h000000, 9'd0, 12'd257, 7'd101, ckb_pkg::MODE_GREY, 1'b0);
		@(negedge clk);
		queue_px(24'hFFFFFF, 24'h000000);
		queue_px(24'hFF0000, 24'h00FF00);
		queue_px(24'h00FF00, 24'hFF00FF);
		drain();

		// Zero opacity passes the background
		set_regs(24'h000000, 9'd0, 12'hFFF, 7'd0, ckb_pkg::MODE_NONE, 1'b0);
		@(negedge clk);
		queue_px(24'hFFFFFF, 24'h123456);
		queue_px(24'h7F7F7F, 24'hFEDCBA);
		drain();

		// Random words under random settings, one idling pattern per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			for (int st = 0; st < SETS_PER_PH; st++) begin
				random_regs();
				@(negedge clk);
				for (int n = 0; n < PIXELS_PER; n++) begin
					case ($urandom_range(0, 19))
						0: sp = 24'h000000;
						1: sp = WHITE;
						2, 3, 4, 5, 6, 7, 8: sp = near_key_pixel();
						default: sp = 24'($urandom);
					endcase
					queue_px(sp, 24'($urandom));
				end
				drain();
			end
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
